### hw/rtl/nsf_pkg.sv
package nsf_pkg;

  // Default sizes of the byte ring, the descriptor queue and the longest sentence.
  localparam int NSF_RING_DEPTH   = 1024;
  localparam int NSF_ENTRY_DEPTH  = 16;
  localparam int NSF_MAX_SENTENCE = 256;

  // Largest ring index a read can form before it wraps: start plus offset.
  localparam int RD_SUM_MAX = 1023 + 255;
  localparam int RD_SUM_W   = 11;

  // Characters with a framing meaning.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // Sentence kinds.
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_NMEA    = 2'd1;

  // Operation codes carried with each input item.
  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_POP     = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Framer state: hunting for a dollar sign or collecting a sentence.
  typedef enum logic {
    ST_HUNT    = 1'b0,
    ST_COLLECT = 1'b1
  } framer_state_t;

  // Framer requests for one received character.
  typedef struct packed {
    logic ring_wr;
    logic push;
    logic done;
  } nsf_rx_t;

  // Byte ring accesses for one item.
  typedef struct packed {
    logic wr;
    logic rd;
  } nsf_ring_ctl_t;

  // Descriptor queue accesses for one item.
  typedef struct packed {
    logic push;
    logic pop;
  } nsf_q_ctl_t;

endpackage

### hw/rtl/nsf_in_if.sv
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [9:0] read_start;
  logic [7:0] read_offset;
  logic [8:0] read_length;

  modport source (
    output valid, operation, rx_byte, read_start, read_offset, read_length,
    input  ready
  );

  modport sink (
    input  valid, operation, rx_byte, read_start, read_offset, read_length,
    output ready
  );
endinterface

### hw/rtl/nsf_out_if.sv
interface nsf_out_if;
  logic        valid;
  logic        ready;
  logic        desc_valid;
  logic [1:0]  desc_kind;
  logic [9:0]  desc_start;
  logic [8:0]  desc_length;
  logic [7:0]  read_data;
  logic        read_last;
  logic        sentence_done;
  logic [31:0] sync_total;
  logic [31:0] overflow_total;
  logic [4:0]  pending_total;

  modport source (
    output valid, desc_valid, desc_kind, desc_start, desc_length, read_data, read_last,
           sentence_done, sync_total, overflow_total, pending_total,
    input  ready
  );

  modport sink (
    input  valid, desc_valid, desc_kind, desc_start, desc_length, read_data, read_last,
           sentence_done, sync_total, overflow_total, pending_total,
    output ready
  );
endinterface

### hw/rtl/nsf_framer.sv
module nsf_framer import nsf_pkg::*; #(
  parameter int RW           = 10,
  parameter int LW           = 9,
  parameter int MAX_SENTENCE = NSF_MAX_SENTENCE
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_en,
  input  logic [7:0]    rx_byte,
  input  logic [RW-1:0] ring_head,
  output nsf_rx_t       rx,
  output logic [7:0]    wr_byte,
  output logic [RW-1:0] push_start,
  output logic [LW-1:0] push_len
);

  framer_state_t state, state_next;
  logic [RW-1:0] cur_start, cur_start_next;
  logic [LW-1:0] cur_len, cur_len_next;
  logic [LW-1:0] len_inc;

  // State register; the open sentence's start and length are payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
    cur_start <= cur_start_next;
    cur_len   <= cur_len_next;
  end

  // Character decode for one received byte.
  always_comb begin
    state_next     = state;
    cur_start_next = cur_start;
    cur_len_next   = cur_len;
    rx             = '0;
    wr_byte        = rx_byte;
    len_inc        = cur_len + LW'(1);
    if (rx_en && rx_byte != CH_LF) begin
      unique case (state)
        ST_HUNT: begin
          if (rx_byte == CH_DOLLAR) begin
            state_next     = ST_COLLECT;
            cur_start_next = ring_head;
            cur_len_next   = LW'(1);
            rx.ring_wr     = 1'b1;
          end
        end
        ST_COLLECT: begin
          if (rx_byte == CH_CR) begin
            // Sentence complete: hand its descriptor to the queue.
            state_next = ST_HUNT;
            rx.push    = 1'b1;
            rx.done    = 1'b1;
          end else if (rx_byte == CH_DOLLAR) begin
            // A new dollar sign restarts the sentence at the same queue entry.
            cur_start_next = ring_head;
            cur_len_next   = LW'(1);
            rx.ring_wr     = 1'b1;
          end else begin
            rx.ring_wr   = 1'b1;
            cur_len_next = len_inc;
            // Too long: drop the sentence without queuing it.
            if (len_inc == LW'(MAX_SENTENCE)) begin
              state_next = ST_HUNT;
            end
          end
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

  assign push_start = cur_start;
  assign push_len   = cur_len;

`ifndef SYNTHESIS
  // An open sentence always holds at least the dollar sign and stays below the limit.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_COLLECT |-> (cur_len != '0) && (cur_len < LW'(MAX_SENTENCE)))
    else $error("open sentence length out of range");
`endif

endmodule

### hw/rtl/nsf_ring.sv
module nsf_ring import nsf_pkg::*; #(
  parameter int RING_DEPTH = NSF_RING_DEPTH,
  parameter int RW         = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  nsf_ring_ctl_t ctl,
  input  logic [7:0]    wr_byte,
  input  logic [9:0]    read_start,
  input  logic [7:0]    read_offset,
  output logic [RW-1:0] ring_head,
  output logic [7:0]    rd_data
);

  localparam int AW        = (RW + 1 > RD_SUM_W) ? RW + 1 : RD_SUM_W;
  localparam int FoldSteps = RD_SUM_MAX / RING_DEPTH;

  logic [7:0]    ring_mem [RING_DEPTH];
  logic [AW-1:0] sum;
  logic [RW-1:0] rd_addr;

  // Read index: start plus offset, folded back into the ring a step at a time.
  always_comb begin
    sum = AW'(read_start) + AW'(read_offset);
    for (int i = 0; i < FoldSteps; i++) begin
      if (sum >= AW'(RING_DEPTH)) begin
        sum = sum - AW'(RING_DEPTH);
      end
    end
  end

  assign rd_addr = sum[RW-1:0];

  // Write pointer wraps at the ring depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head <= '0;
    end else if (ctl.wr) begin
      ring_head <= (ring_head == RW'(RING_DEPTH - 1)) ? '0 : ring_head + RW'(1);
    end
  end

  // Byte memory with one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      ring_mem[ring_head] <= wr_byte;
    end
    if (ctl.rd) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

endmodule

### hw/rtl/nsf_desc.sv
module nsf_desc import nsf_pkg::*; #(
  parameter int ENTRY_DEPTH = NSF_ENTRY_DEPTH,
  parameter int RW          = 10,
  parameter int LW          = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  nsf_q_ctl_t    ctl,
  input  logic [RW-1:0] push_start,
  input  logic [LW-1:0] push_len,
  output logic          pop_hit,
  output logic [RW-1:0] rd_start,
  output logic [LW-1:0] rd_len,
  output logic [31:0]   sync_next,
  output logic [31:0]   overflow_next,
  output logic [$clog2(ENTRY_DEPTH)-1:0] pending_next
);

  localparam int EW = $clog2(ENTRY_DEPTH);

  logic [RW+LW-1:0] desc_mem [ENTRY_DEPTH];
  logic [RW+LW-1:0] rd_word;
  logic [EW-1:0]    head, head_next, head_inc;
  logic [EW-1:0]    tail, tail_next, tail_inc;
  logic [31:0]      sync_count, overflow_count;
  logic [EW-1:0]    pending_count;

  // Pointer and counter update for a push or a pop.
  always_comb begin
    head_inc      = (head == EW'(ENTRY_DEPTH - 1)) ? '0 : head + EW'(1);
    tail_inc      = (tail == EW'(ENTRY_DEPTH - 1)) ? '0 : tail + EW'(1);
    head_next     = head;
    tail_next     = tail;
    sync_next     = sync_count;
    overflow_next = overflow_count;
    pending_next  = pending_count;
    pop_hit       = ctl.pop && (head != tail);
    if (ctl.push) begin
      sync_next = sync_count + 32'd1;
      head_next = head_inc;
      // Queue full after this push: the oldest descriptor is dropped.
      if (head_inc == tail) begin
        overflow_next = overflow_count + 32'd1;
        tail_next     = tail_inc;
      end else begin
        pending_next = pending_count + EW'(1);
      end
    end else if (pop_hit) begin
      tail_next = tail_inc;
      if (pending_count != '0) begin
        pending_next = pending_count - EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      tail           <= '0;
      sync_count     <= '0;
      overflow_count <= '0;
      pending_count  <= '0;
    end else begin
      head           <= head_next;
      tail           <= tail_next;
      sync_count     <= sync_next;
      overflow_count <= overflow_next;
      pending_count  <= pending_next;
    end
  end

  // Descriptor memory. Only completed sentences are written, so every entry
  // between tail and head is of the NMEA kind.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      desc_mem[head] <= {push_start, push_len};
    end
    if (pop_hit) begin
      rd_word <= desc_mem[tail];
    end
  end

  assign rd_start = rd_word[RW+LW-1:LW];
  assign rd_len   = rd_word[LW-1:0];

`ifndef SYNTHESIS
  logic [EW-1:0] occupancy;

  always_comb begin
    occupancy = (head >= tail) ? head - tail : EW'(ENTRY_DEPTH) - tail + head;
  end

  // The pending count tracks the distance between the pointers.
  a_pending_occ: assert property (@(posedge clk) disable iff (rst)
    pending_count == occupancy)
    else $error("pending count disagrees with queue occupancy");

  // A push that drops the oldest entry keeps the queue full.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push && (head_inc == tail) |=> pending_count == EW'(ENTRY_DEPTH - 1))
    else $error("queue not full after overflow");
`endif

endmodule

### hw/rtl/nmea_sentence_framer_queue.sv
// NMEA sentence framer with a descriptor queue. Each accepted item is a
// receive, pop or read operation and yields exactly one result. Each item
// passes through the first stage, where the synchronous byte ring and
// descriptor memories are read, and then the output register. Throughput is
// one item per cycle as long as results are taken; it is set by the at most
// one access each item makes to the byte ring or the descriptor memory.
// Sentences are framed from '$' to CR, stored in the byte ring, and queued
// as (start, length) descriptors that a pop returns; a read fetches one
// stored byte at start plus offset. No clearing pass runs after reset.
module nmea_sentence_framer_queue import nsf_pkg::*; #(
  parameter int RING_DEPTH   = NSF_RING_DEPTH,
  parameter int ENTRY_DEPTH  = NSF_ENTRY_DEPTH,
  parameter int MAX_SENTENCE = NSF_MAX_SENTENCE
) (
  input logic       clk,
  input logic       rst,
  nsf_in_if.sink    req,
  nsf_out_if.source rsp
);

  localparam int RW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(MAX_SENTENCE + 1);
  localparam int EW = $clog2(ENTRY_DEPTH);

  logic          accept;
  logic          is_rx, is_pop, is_rd;
  logic          rd_last;
  nsf_rx_t       rx;
  nsf_ring_ctl_t ring_ctl;
  nsf_q_ctl_t    q_ctl;
  logic [7:0]    wr_byte;
  logic [RW-1:0] ring_head;
  logic [RW-1:0] push_start;
  logic [LW-1:0] push_len;
  logic [7:0]    ring_rd_data;
  logic          pop_hit;
  logic [RW-1:0] desc_rd_start;
  logic [LW-1:0] desc_rd_len;
  logic [31:0]   sync_next, overflow_next;
  logic [EW-1:0] pending_next;

  // First stage: item issued to the memories, waiting for read data.
  logic          s1_valid, s1_move;
  logic          s1_pop_hit, s1_read, s1_last, s1_done;
  logic [31:0]   s1_sync, s1_overflow;
  logic [EW-1:0] s1_pending;

  // Output register.
  logic          out_valid;
  logic          out_desc_valid;
  logic [1:0]    out_desc_kind;
  logic [9:0]    out_desc_start;
  logic [8:0]    out_desc_length;
  logic [7:0]    out_read_data;
  logic          out_read_last;
  logic          out_done;
  logic [31:0]   out_sync, out_overflow;
  logic [4:0]    out_pending;

  // Handshake: a new item enters whenever the first stage is free or moving on.
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  // Operation decode; the unused code does nothing.
  always_comb begin
    is_rx  = 1'b0;
    is_pop = 1'b0;
    is_rd  = 1'b0;
    unique case (op_t'(req.operation))
      OP_RECEIVE: is_rx  = 1'b1;
      OP_POP:     is_pop = 1'b1;
      OP_READ:    is_rd  = 1'b1;
      default:    ;
    endcase
  end

  assign rd_last = ({1'b0, req.read_offset} + 9'd1) == req.read_length;

  nsf_framer #(
    .RW           (RW),
    .LW           (LW),
    .MAX_SENTENCE (MAX_SENTENCE)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .rx_en      (accept && is_rx),
    .rx_byte    (req.rx_byte),
    .ring_head  (ring_head),
    .rx         (rx),
    .wr_byte    (wr_byte),
    .push_start (push_start),
    .push_len   (push_len)
  );

  assign ring_ctl.wr = rx.ring_wr;
  assign ring_ctl.rd = accept && is_rd;
  assign q_ctl.push  = rx.push;
  assign q_ctl.pop   = accept && is_pop;

  nsf_ring #(
    .RING_DEPTH (RING_DEPTH),
    .RW         (RW)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ring_ctl),
    .wr_byte     (wr_byte),
    .read_start  (req.read_start),
    .read_offset (req.read_offset),
    .ring_head   (ring_head),
    .rd_data     (ring_rd_data)
  );

  nsf_desc #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .RW          (RW),
    .LW          (LW)
  ) u_desc (
    .clk           (clk),
    .rst           (rst),
    .ctl           (q_ctl),
    .push_start    (push_start),
    .push_len      (push_len),
    .pop_hit       (pop_hit),
    .rd_start      (desc_rd_start),
    .rd_len        (desc_rd_len),
    .sync_next     (sync_next),
    .overflow_next (overflow_next),
    .pending_next  (pending_next)
  );

  // First stage keeps the result fields that do not come from a memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_pop_hit  <= pop_hit;
      s1_read     <= is_rd;
      s1_last     <= is_rd && rd_last;
      s1_done     <= rx.done;
      s1_sync     <= sync_next;
      s1_overflow <= overflow_next;
      s1_pending  <= pending_next;
    end
  end

  // Output register merges the memory read data into the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      out_desc_valid  <= s1_pop_hit;
      out_desc_kind   <= s1_pop_hit ? KIND_NMEA : KIND_INVALID;
      out_desc_start  <= s1_pop_hit ? 10'(desc_rd_start) : '0;
      out_desc_length <= s1_pop_hit ? 9'(desc_rd_len) : '0;
      out_read_data   <= s1_read ? ring_rd_data : '0;
      out_read_last   <= s1_last;
      out_done        <= s1_done;
      out_sync        <= s1_sync;
      out_overflow    <= s1_overflow;
      out_pending     <= 5'(s1_pending);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.desc_valid     = out_desc_valid;
  assign rsp.desc_kind      = out_desc_kind;
  assign rsp.desc_start     = out_desc_start;
  assign rsp.desc_length    = out_desc_length;
  assign rsp.read_data      = out_read_data;
  assign rsp.read_last      = out_read_last;
  assign rsp.sentence_done  = out_done;
  assign rsp.sync_total     = out_sync;
  assign rsp.overflow_total = out_overflow;
  assign rsp.pending_total  = out_pending;

`ifndef SYNTHESIS
  // Every transfer in occupies the first stage on the next cycle.
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item missing from first stage");

  // A completed sentence comes only from a receive item.
  a_done_rx: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_done |-> !s1_pop_hit && !s1_read)
    else $error("sentence done flagged on a pop or read");

  // Popped descriptor data must hold while the first stage is stalled.
  a_desc_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pop_hit && !s1_move |=> $stable(desc_rd_start) && $stable(desc_rd_len))
    else $error("descriptor read data changed during stall");
`endif

endmodule

### dv/nmea_sentence_framer_queue_tb.sv
`timescale 1ns / 100ps

module nmea_sentence_framer_queue_tb;
  import nsf_pkg::*;

  // The one operation code that the package does not name; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_SENTENCES = 1;
  localparam int ITEM_TARGET = 400;

  // One request and one response as the channels carry them.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic [9:0] rd_start;
    logic [7:0] rd_offset;
    logic [8:0] rd_length;
  } framer_req_t;

  typedef struct packed {
    logic        desc_valid;
    logic [1:0]  desc_kind;
    logic [9:0]  desc_start;
    logic [8:0]  desc_length;
    logic [7:0]  read_data;
    logic        read_last;
    logic        sentence_done;
    logic [31:0] sync_total;
    logic [31:0] overflow_total;
    logic [4:0]  pending_total;
  } framer_rsp_t;

  // Shadow copy of the framer: byte ring, descriptor queue and counters.
  typedef struct {
    logic [7:0]  ring [NSF_RING_DEPTH];
    logic [1:0]  kind [NSF_ENTRY_DEPTH];
    logic [9:0]  start [NSF_ENTRY_DEPTH];
    logic [8:0]  length [NSF_ENTRY_DEPTH];
    logic [3:0]  head;
    logic [3:0]  tail;
    logic [9:0]  ring_head;
    logic        collecting;
    logic [31:0] sync_cnt;
    logic [31:0] ovf_cnt;
    logic [4:0]  pend_cnt;
  } framer_model_t;

  logic clk = 1'b0;
  logic rst;

  nsf_in_if  req_ch ();
  nsf_out_if rsp_ch ();

  nmea_sentence_framer_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  framer_model_t gen_model;     // tracks what the stimulus has written so far
  framer_model_t exp_model;     // advanced on each accepted transfer
  framer_req_t   pending_items[$];
  framer_rsp_t   expected_results[$];
  framer_req_t   next_item;
  framer_req_t   taken_item;
  framer_rsp_t   want_rsp;
  framer_rsp_t   got_rsp;
  bit            ring_wrapped;
  int            mismatches;
  int            items_sent;
  int            cycle_count;
  int            burst_left;
  int            gap_left;
  int            hold_left;
  bit            hold_done;
  int            ready_mode;
  int            mode_cycles;
  logic [7:0]    stall_pattern;

  function automatic void clear_model(ref framer_model_t m);
    for (int i = 0; i < NSF_RING_DEPTH; i++) m.ring[i] = 8'h00;
    for (int i = 0; i < NSF_ENTRY_DEPTH; i++) begin
      m.kind[i] = KIND_INVALID;
      m.start[i] = '0;
      m.length[i] = '0;
    end
    m.head = '0;
    m.tail = '0;
    m.ring_head = '0;
    m.collecting = 1'b0;
    m.sync_cnt = '0;
    m.ovf_cnt = '0;
    m.pend_cnt = '0;
  endfunction

  function automatic void store_byte(ref framer_model_t m, input logic [7:0] b);
    m.ring[m.ring_head] = b;
    m.ring_head = m.ring_head + 10'd1;
  endfunction

  // A dollar sign (re)opens the sentence in the slot at the queue head.
  function automatic void open_sentence(ref framer_model_t m);
    m.collecting = 1'b1;
    m.kind[m.head] = KIND_NMEA;
    m.start[m.head] = m.ring_head;
    m.length[m.head] = 9'd1;
    store_byte(m, CH_DOLLAR);
  endfunction

  // Advances the framer by one item and returns the response it produces.
  function automatic framer_rsp_t step_framer(ref framer_model_t m, input framer_req_t it);
    framer_rsp_t r;
    logic [3:0]  slot;
    logic [9:0]  addr;
    r = '0;
    slot = m.head;
    if (it.op == OP_RECEIVE) begin
      if (it.rx == CH_LF) begin
        // Line feeds never matter.
      end else if (!m.collecting) begin
        if (it.rx == CH_DOLLAR) open_sentence(m);
      end else if (it.rx == CH_CR) begin
        m.sync_cnt = m.sync_cnt + 32'd1;
        m.head = m.head + 4'd1;
        if (m.head == m.tail) begin
          m.ovf_cnt = m.ovf_cnt + 32'd1;
          m.tail = m.tail + 4'd1;
        end else begin
          m.pend_cnt = m.pend_cnt + 5'd1;
        end
        m.collecting = 1'b0;
        r.sentence_done = 1'b1;
      end else if (it.rx == CH_DOLLAR) begin
        open_sentence(m);
      end else begin
        store_byte(m, it.rx);
        m.length[slot] = m.length[slot] + 9'd1;
        // Too long: the sentence is dropped and the slot is reused.
        if (m.length[slot] == NSF_MAX_SENTENCE) begin
          m.kind[slot] = KIND_INVALID;
          m.collecting = 1'b0;
        end
      end
    end else if (it.op == OP_POP) begin
      if (m.tail != m.head) begin
        r.desc_valid = 1'b1;
        r.desc_kind = m.kind[m.tail];
        r.desc_start = m.start[m.tail];
        r.desc_length = m.length[m.tail];
        m.kind[m.tail] = KIND_INVALID;
        m.tail = m.tail + 4'd1;
        if (m.pend_cnt != 0) m.pend_cnt = m.pend_cnt - 5'd1;
      end
    end else if (it.op == OP_READ) begin
      addr = it.rd_start + 10'(it.rd_offset);
      r.read_data = m.ring[addr];
      r.read_last = (int'(it.rd_offset) + 1 == int'(it.rd_length));
    end
    r.sync_total = m.sync_cnt;
    r.overflow_total = m.ovf_cnt;
    r.pending_total = m.pend_cnt;
    return r;
  endfunction

  function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Queues one item and keeps the stimulus-side shadow in step with it.
  task automatic queue_item(logic [1:0] op, logic [7:0] rx, logic [9:0] rs, logic [7:0] ro,
                            logic [8:0] rl);
    framer_req_t it;
    logic [9:0]  prev_head;
    it = '{op: op, rx: rx, rd_start: rs, rd_offset: ro, rd_length: rl};
    prev_head = gen_model.ring_head;
    void'(step_framer(gen_model, it));
    if (gen_model.ring_head < prev_head) ring_wrapped = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic queue_rx(logic [7:0] b);
    queue_item(OP_RECEIVE, b, 10'($urandom), 8'($urandom), 9'($urandom));
  endtask

  task automatic queue_pop();
    queue_item(OP_POP, 8'($urandom), 10'($urandom), 8'($urandom), 9'($urandom));
  endtask

  // A read only ever lands on a ring byte that has already been written.
  task automatic queue_read();
    logic [9:0] target;
    logic [7:0] off;
    logic [8:0] len;
    int         pick;
    if (!ring_wrapped && gen_model.ring_head == 0) begin
      queue_pop();
    end else begin
      target = ring_wrapped ? 10'($urandom_range(0, NSF_RING_DEPTH - 1))
                            : 10'($urandom_range(0, gen_model.ring_head - 1));
      off = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      pick = $urandom_range(0, 5);
      if (pick < 2) len = 9'(off) + 9'd1;
      else if (pick == 2) len = '0;
      else len = 9'($urandom);
      queue_item(OP_READ, 8'($urandom), target - 10'(off), off, len);
    end
  endtask

  // One sentence from dollar to CR; payload mostly clean, sometimes left unterminated.
  task automatic queue_sentence(int payload, bit clean);
    logic [7:0] b;
    queue_rx(CH_DOLLAR);
    for (int i = 0; i < payload; i++) begin
      b = 8'($urandom);
      if (clean && (b == CH_CR || b == CH_DOLLAR || b == CH_LF)) b = 8'h2A;
      queue_rx(b);
    end
    if ($urandom_range(0, 6) != 0) begin
      queue_rx(CH_CR);
      if ($urandom_range(0, 1) == 0) queue_rx(CH_LF);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
      items_sent <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_item = '{op: req_ch.operation, rx: req_ch.rx_byte, rd_start: req_ch.read_start,
                       rd_offset: req_ch.read_offset, rd_length: req_ch.read_length};
        expected_results.push_back(step_framer(exp_model, taken_item));
        items_sent <= items_sent + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.operation <= next_item.op;
          req_ch.rx_byte <= next_item.rx;
          req_ch.read_start <= next_item.rd_start;
          req_ch.read_offset <= next_item.rd_offset;
          req_ch.read_length <= next_item.rd_length;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random mode changes, plus one long hold-off to back up the block.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      ready_mode <= 0;
      mode_cycles <= 0;
      stall_pattern <= 8'hA5;
    end else begin
      mode_cycles <= mode_cycles + 1;
      if (mode_cycles % 64 == 63) begin
        ready_mode <= $urandom_range(0, 2);
        stall_pattern <= 8'($urandom);
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && items_sent >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 90;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: begin
            rsp_ch.ready <= 1'b1;
          end
          1: begin
            rsp_ch.ready <= stall_pattern[mode_cycles % 8];
          end
          default: begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Response checker: every transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: response with nothing expected: expected none, got sync_total 0x%0h",
                 $time, rsp_ch.sync_total);
        mismatches = mismatches + 1;
      end else begin
        want_rsp = expected_results.pop_front();
        got_rsp = '{desc_valid: rsp_ch.desc_valid, desc_kind: rsp_ch.desc_kind,
                    desc_start: rsp_ch.desc_start, desc_length: rsp_ch.desc_length,
                    read_data: rsp_ch.read_data, read_last: rsp_ch.read_last,
                    sentence_done: rsp_ch.sentence_done, sync_total: rsp_ch.sync_total,
                    overflow_total: rsp_ch.overflow_total,
                    pending_total: rsp_ch.pending_total};
        mismatches = mismatches
          + check_field("desc_valid", 32'(want_rsp.desc_valid), 32'(got_rsp.desc_valid))
          + check_field("desc_kind", 32'(want_rsp.desc_kind), 32'(got_rsp.desc_kind))
          + check_field("desc_start", 32'(want_rsp.desc_start), 32'(got_rsp.desc_start))
          + check_field("desc_length", 32'(want_rsp.desc_length), 32'(got_rsp.desc_length))
          + check_field("read_data", 32'(want_rsp.read_data), 32'(got_rsp.read_data))
          + check_field("read_last", 32'(want_rsp.read_last), 32'(got_rsp.read_last))
          + check_field("sentence_done", 32'(want_rsp.sentence_done),
                        32'(got_rsp.sentence_done))
          + check_field("sync_total", want_rsp.sync_total, got_rsp.sync_total)
          + check_field("overflow_total", want_rsp.overflow_total, got_rsp.overflow_total)
          + check_field("pending_total", 32'(want_rsp.pending_total),
                        32'(got_rsp.pending_total));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int  longs;
    int  sel;
    int  op;
    bit  hold_pops;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_RECEIVE;
    req_ch.rx_byte = '0;
    req_ch.read_start = '0;
    req_ch.read_offset = '0;
    req_ch.read_length = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    ring_wrapped = 1'b0;
    clear_model(gen_model);
    clear_model(exp_model);

    // Directed opening: empty pop, unused code, line feed and stray bytes outside a
    // sentence, extreme payload bytes, restart on a second dollar, CR, then reads.
    queue_pop();
    queue_item(OP_UNUSED, 8'hFF, 10'h3FF, 8'hFF, 9'h1FF);
    queue_rx(CH_LF);
    queue_rx(8'h41);
    queue_rx(CH_CR);
    queue_rx(CH_DOLLAR);
    queue_rx(8'h47);
    queue_rx(8'hFF);
    queue_rx(8'h00);
    queue_rx(CH_LF);
    queue_rx(CH_DOLLAR);
    queue_rx(8'h50);
    queue_rx(CH_CR);
    queue_rx(CH_LF);
    queue_item(OP_READ, 8'h00, 10'd0, 8'd0, 9'd3);
    queue_item(OP_READ, 8'hFF, 10'd1023, 8'd1, 9'd2);
    queue_item(OP_READ, 8'h00, 10'd4, 8'd1, 9'd2);
    queue_item(OP_READ, 8'h00, 10'd0, 8'd3, 9'd0);
    queue_item(OP_READ, 8'h00, 10'd774, 8'd255, 9'd256);
    queue_item(OP_READ, 8'h00, 10'd3, 8'd2, 9'h1FF);
    queue_pop();
    queue_pop();

    // Short sentences with no pops between them, enough to fill the queue and drop
    // the oldest descriptors.
    for (int i = 0; i < NSF_ENTRY_DEPTH + 2; i++) begin
      queue_rx(CH_DOLLAR);
      queue_rx(8'h41);
      queue_rx(CH_CR);
    end

    // Random part: mostly framed sentences, with pops and reads in between, stretches
    // without pops so the queue overflows, and one maximum-length sentence.
    longs = 0;
    hold_pops = 1'b0;
    while (pending_items.size() < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (longs < LONG_SENTENCES && pending_items.size() >= 120 * (longs + 1)) begin
        // Payload that takes the sentence exactly to the limit, so it is dropped.
        queue_sentence(NSF_MAX_SENTENCE - 1, 1'b1);
        longs = longs + 1;
      end else if (sel < 50) begin
        queue_sentence($urandom_range(0, 24), $urandom_range(0, 9) != 0);
      end else if (sel < 70) begin
        if (!hold_pops) queue_pop();
      end else if (sel < 92) begin
        queue_read();
      end else begin
        op = $urandom_range(0, 3);
        if (op == OP_READ) queue_read();
        else queue_item(2'(op), 8'($urandom), 10'($urandom), 8'($urandom), 9'($urandom));
      end
      if (hold_pops ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 24) == 0))
        hold_pops = !hold_pops;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything answered, then a few quiet cycles.
    @(negedge clk);
    while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/nsf_pkg.sv
hw/rtl/nsf_in_if.sv
hw/rtl/nsf_out_if.sv
hw/rtl/nsf_framer.sv
hw/rtl/nsf_ring.sv
hw/rtl/nsf_desc.sv
hw/rtl/nmea_sentence_framer_queue.sv
dv/nmea_sentence_framer_queue_tb.sv
